FILE: hw/rtl/obbta_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box to aligned box transform: shared definitions
// Widths, register indexes, reset values and payload types of the block.
// ----------------------------------------------------------------------------
package obbta_pkg;

    localparam int DATA_W     = 24;
    localparam int COEF_W     = 18;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 16;
    localparam int XF_W       = ACC_W - FRAC_SHIFT;
    localparam int CTR_W      = XF_W + 1;
    localparam int ABS_W      = XF_W;
    localparam int ESUM_W     = ABS_W + 2;
    localparam int BOX_W      = ESUM_W + 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd5;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SHIFT);
    localparam logic [ROW_W-1:0]  ROW_X_RST = ROW_W'(COEF_ONE);
    localparam logic [ROW_W-1:0]  ROW_Y_RST = ROW_W'(COEF_ONE) << COEF_W;
    localparam logic [ROW_W-1:0]  ROW_Z_RST = ROW_W'(COEF_ONE) << (2 * COEF_W);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
    localparam logic signed [BOX_W-1:0] SAT_HI = BOX_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [BOX_W-1:0] SAT_LO = BOX_W'(-(2 ** (DATA_W - 1)));

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef fix_t                     vec3_t [3];
    typedef logic signed [XF_W-1:0]   xf_t;
    typedef xf_t                      xf3_t [3];
    typedef logic [ROW_W-1:0]         row_t;
    typedef row_t                     mat_t [3];

    typedef struct packed {
        logic s1;
        logic s2;
    } xf_en_t;

    typedef struct packed {
        fix_t center_x;
        fix_t center_y;
        fix_t center_z;
        fix_t axis_a_x;
        fix_t axis_a_y;
        fix_t axis_a_z;
        fix_t axis_b_x;
        fix_t axis_b_y;
        fix_t axis_b_z;
        fix_t axis_c_x;
        fix_t axis_c_y;
        fix_t axis_c_z;
    } box_t;

    typedef struct packed {
        fix_t min_x;
        fix_t min_y;
        fix_t min_z;
        fix_t max_x;
        fix_t max_y;
        fix_t max_z;
    } aabb_t;

endpackage

FILE: hw/rtl/obbta_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface obbta_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

FILE: hw/rtl/obbta_xform.sv
// ----------------------------------------------------------------------------
// Vector by matrix transform
// Two register stages: nine products, then column sums rounded to Q19.8.
// ----------------------------------------------------------------------------
module obbta_xform
    import obbta_pkg::*;
(
    input  logic   clk,
    input  xf_en_t en,
    input  vec3_t  vec,
    input  mat_t   mat,
    output xf3_t   xf
);

    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [ACC_W-1:0]  acc [3];
    xf_t                      xf_reg [3];
    xf_t                      xf_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = vec[r] * $signed(mat[r][COEF_W*c +: COEF_W]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = ACC_W'(prod_reg[0][c]) + ACC_W'(prod_reg[1][c])
                   + ACC_W'(prod_reg[2][c]) + ROUND_BIAS;
            xf_next[c] = acc[c][ACC_W-1:FRAC_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
        end
        if (en.s2)
        begin
            xf_reg <= xf_next;
        end
    end

    assign xf = xf_reg;

endmodule

FILE: hw/rtl/obb_transform_to_aabb.sv
// ----------------------------------------------------------------------------
// Oriented box to aligned box transform
// Transforms an oriented box by a 3x3 matrix and offset and emits its
// axis-aligned bounds, saturated to Q15.8.
// Boxes pass in order through the five-stage transform and bounds pipeline.
// Throughput is one box per cycle while the output side is not stalled.
// Reset clears all stage valid bits and loads the identity matrix, zero offset.
// ----------------------------------------------------------------------------
module obb_transform_to_aabb
    import obbta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    obbta_stream_if.sink         box,
    obbta_stream_if.source       aabb,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data
);

    localparam int STAGES = 5;

    mat_t                     mat_reg;
    fix_t                     off_reg [3];

    logic [STAGES-1:0]        valid_reg;
    logic [STAGES-1:0]        valid_next;
    logic [STAGES-1:0]        rdy;

    vec3_t                    vec_ctr;
    vec3_t                    vec_a;
    vec3_t                    vec_b;
    vec3_t                    vec_c;
    xf3_t                     xf_ctr;
    xf3_t                     xf_a;
    xf3_t                     xf_b;
    xf3_t                     xf_c;
    xf_en_t                   xf_en;

    logic signed [CTR_W-1:0]  ctr3_reg [3];
    logic signed [CTR_W-1:0]  ctr3_next [3];
    logic [ABS_W-1:0]         abs3_reg [3][3];
    logic [ABS_W-1:0]         abs3_next [3][3];
    logic signed [CTR_W-1:0]  ctr4_reg [3];
    logic [ESUM_W-1:0]        esum4_reg [3];
    logic [ESUM_W-1:0]        esum4_next [3];
    logic signed [BOX_W-1:0]  lo [3];
    logic signed [BOX_W-1:0]  hi [3];
    aabb_t                    out_reg;
    aabb_t                    out_next;

    function automatic fix_t sat(input logic signed [BOX_W-1:0] x);
        fix_t r;
        if (x > SAT_HI)
        begin
            r = SAT_HI[DATA_W-1:0];
        end
        else if (x < SAT_LO)
        begin
            r = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ABS_W-1:0] abs_xf(input xf_t x);
        logic [ABS_W-1:0] r;
        if (x < 0)
        begin
            r = ABS_W'(-x);
        end
        else
        begin
            r = ABS_W'(x);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ROW_X_RST;
            mat_reg[1] <= ROW_Y_RST;
            mat_reg[2] <= ROW_Z_RST;
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_X: mat_reg[0] <= cfg_data;
                REG_ROW_Y: mat_reg[1] <= cfg_data;
                REG_ROW_Z: mat_reg[2] <= cfg_data;
                REG_OFF_X: off_reg[0] <= cfg_data[DATA_W-1:0];
                REG_OFF_Y: off_reg[1] <= cfg_data[DATA_W-1:0];
                REG_OFF_Z: off_reg[2] <= cfg_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage takes new data whenever it is empty or its contents move on.
    always_comb
    begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || aabb.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? box.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign box.ready = rdy[0];
    assign xf_en.s1  = rdy[0];
    assign xf_en.s2  = rdy[1];

    assign vec_ctr[0] = box.payload.center_x;
    assign vec_ctr[1] = box.payload.center_y;
    assign vec_ctr[2] = box.payload.center_z;
    assign vec_a[0]   = box.payload.axis_a_x;
    assign vec_a[1]   = box.payload.axis_a_y;
    assign vec_a[2]   = box.payload.axis_a_z;
    assign vec_b[0]   = box.payload.axis_b_x;
    assign vec_b[1]   = box.payload.axis_b_y;
    assign vec_b[2]   = box.payload.axis_b_z;
    assign vec_c[0]   = box.payload.axis_c_x;
    assign vec_c[1]   = box.payload.axis_c_y;
    assign vec_c[2]   = box.payload.axis_c_z;

    obbta_xform u_xform_ctr (
        .clk (clk),
        .en  (xf_en),
        .vec (vec_ctr),
        .mat (mat_reg),
        .xf  (xf_ctr)
    );

    obbta_xform u_xform_a (
        .clk (clk),
        .en  (xf_en),
        .vec (vec_a),
        .mat (mat_reg),
        .xf  (xf_a)
    );

    obbta_xform u_xform_b (
        .clk (clk),
        .en  (xf_en),
        .vec (vec_b),
        .mat (mat_reg),
        .xf  (xf_b)
    );

    obbta_xform u_xform_c (
        .clk (clk),
        .en  (xf_en),
        .vec (vec_c),
        .mat (mat_reg),
        .xf  (xf_c)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctr3_next[i]    = CTR_W'(xf_ctr[i]) + CTR_W'(off_reg[i]);
            abs3_next[0][i] = abs_xf(xf_a[i]);
            abs3_next[1][i] = abs_xf(xf_b[i]);
            abs3_next[2][i] = abs_xf(xf_c[i]);
            esum4_next[i]   = ESUM_W'(abs3_reg[0][i]) + ESUM_W'(abs3_reg[1][i])
                            + ESUM_W'(abs3_reg[2][i]);
            lo[i]           = BOX_W'(ctr4_reg[i]) - BOX_W'(esum4_reg[i]);
            hi[i]           = BOX_W'(ctr4_reg[i]) + BOX_W'(esum4_reg[i]);
        end
        out_next.min_x = sat(lo[0]);
        out_next.min_y = sat(lo[1]);
        out_next.min_z = sat(lo[2]);
        out_next.max_x = sat(hi[0]);
        out_next.max_y = sat(hi[1]);
        out_next.max_z = sat(hi[2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            ctr3_reg <= ctr3_next;
            abs3_reg <= abs3_next;
        end
        if (rdy[3])
        begin
            ctr4_reg  <= ctr3_reg;
            esum4_reg <= esum4_next;
        end
        if (rdy[4])
        begin
            out_reg <= out_next;
        end
    end

    assign aabb.valid   = valid_reg[STAGES-1];
    assign aabb.payload = out_reg;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        aabb.ready |-> box.ready
    ) else $error("Input stalled while the output side was ready.");

    a_min_le_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        aabb.valid |-> ($signed(aabb.payload.min_x) <= $signed(aabb.payload.max_x)
                     && $signed(aabb.payload.min_y) <= $signed(aabb.payload.max_y)
                     && $signed(aabb.payload.min_z) <= $signed(aabb.payload.max_z))
    ) else $error("Aligned box minimum exceeds its maximum.");

    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (box.valid && box.ready) ##1 aabb.ready ##1 aabb.ready ##1 aabb.ready
            ##1 aabb.ready |=> aabb.valid
    ) else $error("Accepted transaction did not reach the output in five cycles.");
`endif

endmodule

FILE: sim/tb_obb_transform_to_aabb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: oriented box to aligned box transform
// A directed table of boxes and register writes runs first. Random boxes
// follow under several matrix and offset settings and idle and stall patterns.
// Every aligned box is checked field by field against a hand-written expectation or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_obb_transform_to_aabb;
    import obbta_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 108;
    localparam int PHASES       = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int V_MAX        = 8388607;
    localparam int V_MIN        = -8388608;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (FRAC_SHIFT - 1));
    localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W - 1){1'b0}}};

    typedef enum logic {STEP_WRITE, STEP_BOX} step_kind_e;

    typedef struct {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] idx;
        row_t                 val;
        box_t                 item;
        bit                   typed;
        aabb_t                want;
    } plan_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    row_t                 cfg_data;
    logic                 hold_rx = 1'b0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    row_t       mat_q [3];
    fix_t       off_q [3];
    aabb_t      aabb_q [$];
    plan_step_t plan_q [$];

    string fld_name [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

    aabb_t                 want_box;
    logic [6*DATA_W-1:0]   got_flat;
    logic [6*DATA_W-1:0]   want_flat;

    obbta_stream_if #(.payload_t(box_t))  box_if ();
    obbta_stream_if #(.payload_t(aabb_t)) aabb_if ();

    obb_transform_to_aabb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box_if),
        .aabb      (aabb_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint coef_at(input row_t r, input int col);
        logic signed [COEF_W-1:0] k;
        k = r[col*COEF_W +: COEF_W];
        return longint'(k);
    endfunction

    function automatic longint xform_comp(input fix_t vx, input fix_t vy, input fix_t vz,
                                          input int col);
        longint acc;
        acc = longint'(vx) * coef_at(mat_q[0], col)
            + longint'(vy) * coef_at(mat_q[1], col)
            + longint'(vz) * coef_at(mat_q[2], col);
        return (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    endfunction

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic fix_t sat_fix(input longint x);
        if (x > V_MAX)
        begin
            return fix_t'(V_MAX);
        end
        if (x < V_MIN)
        begin
            return fix_t'(V_MIN);
        end
        return fix_t'(x);
    endfunction

    function automatic aabb_t predict_aabb(input box_t b);
        logic [12*DATA_W-1:0] in_flat;
        logic [6*DATA_W-1:0]  out_flat;
        fix_t                 v [12];
        longint               ctr;
        longint               ext;
        in_flat = b;
        for (int i = 0; i < 12; i++)
        begin
            v[i] = in_flat[(11 - i)*DATA_W +: DATA_W];
        end
        for (int j = 0; j < 3; j++)
        begin
            ctr = xform_comp(v[0], v[1], v[2], j) + longint'(off_q[j]);
            ext = mag(xform_comp(v[3], v[4], v[5], j))
                + mag(xform_comp(v[6], v[7], v[8], j))
                + mag(xform_comp(v[9], v[10], v[11], j));
            out_flat[(5 - j)*DATA_W +: DATA_W] = sat_fix(ctr - ext);
            out_flat[(2 - j)*DATA_W +: DATA_W] = sat_fix(ctr + ext);
        end
        return aabb_t'(out_flat);
    endfunction

    function automatic box_t pack_box(input int c0, input int c1, input int c2,
                                      input int a0, input int a1, input int a2,
                                      input int b0, input int b1, input int b2,
                                      input int k0, input int k1, input int k2);
        return {fix_t'(c0), fix_t'(c1), fix_t'(c2), fix_t'(a0), fix_t'(a1), fix_t'(a2),
                fix_t'(b0), fix_t'(b1), fix_t'(b2), fix_t'(k0), fix_t'(k1), fix_t'(k2)};
    endfunction

    function automatic aabb_t pack_aabb(input int lx, input int ly, input int lz,
                                        input int hx, input int hy, input int hz);
        return {fix_t'(lx), fix_t'(ly), fix_t'(lz), fix_t'(hx), fix_t'(hy), fix_t'(hz)};
    endfunction

    function automatic row_t pack_row(input logic [COEF_W-1:0] kx, input logic [COEF_W-1:0] ky,
                                      input logic [COEF_W-1:0] kz);
        return {kz, ky, kx};
    endfunction

    function automatic fix_t rand_fix();
        int pick;
        pick = $urandom_range(3);
        if (pick == 0)
        begin
            return fix_t'($urandom);
        end
        if (pick == 1)
        begin
            case ($urandom_range(4))
                0: return fix_t'(V_MAX);
                1: return fix_t'(V_MIN);
                2: return fix_t'(0);
                3: return fix_t'(-1);
                default: return fix_t'(1);
            endcase
        end
        return fix_t'($signed($urandom) >>> $urandom_range(31, 8));
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(3);
        if (pick == 0)
        begin
            return COEF_W'($urandom);
        end
        if (pick == 1)
        begin
            case ($urandom_range(4))
                0: return COEF_MAX;
                1: return COEF_MIN;
                2: return COEF_ONE;
                3: return -COEF_ONE;
                default: return '0;
            endcase
        end
        return COEF_W'($signed($urandom) >>> $urandom_range(31, 14));
    endfunction

    function automatic row_t rand_row();
        return pack_row(rand_coef(), rand_coef(), rand_coef());
    endfunction

    function automatic box_t rand_box();
        logic [12*DATA_W-1:0] flat;
        for (int i = 0; i < 12; i++)
        begin
            flat[i*DATA_W +: DATA_W] = rand_fix();
        end
        return box_t'(flat);
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input row_t val);
        plan_step_t s;
        s = '{kind: STEP_WRITE, idx: idx, val: val, item: '0, typed: 1'b0, want: '0};
        plan_q.push_back(s);
    endfunction

    function automatic void plan_box(input box_t item, input bit typed, input aabb_t want);
        plan_step_t s;
        s = '{kind: STEP_BOX, idx: '0, val: '0, item: item, typed: typed, want: want};
        plan_q.push_back(s);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input row_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_ROW_X: mat_q[0] = val;
            REG_ROW_Y: mat_q[1] = val;
            REG_ROW_Z: mat_q[2] = val;
            REG_OFF_X: off_q[0] = val[DATA_W-1:0];
            REG_OFF_Y: off_q[1] = val[DATA_W-1:0];
            REG_OFF_Z: off_q[2] = val[DATA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_box(input box_t item, input bit typed, input aabb_t want);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            box_if.valid <= 1'b0;
            @(posedge clk);
        end
        box_if.valid   <= 1'b1;
        box_if.payload <= item;
        @(posedge clk);
        while (!box_if.ready)
        begin
            @(posedge clk);
        end
        aabb_q.push_back(typed ? want : predict_aabb(item));
    endtask

    task automatic drain();
        box_if.valid <= 1'b0;
        while (aabb_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hold_receiver(input int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        aabb_if.ready <= rst_n && !hold_rx && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && aabb_if.valid && aabb_if.ready)
        begin
            if (aabb_q.size() == 0)
            begin
                err_cnt = err_cnt + 1;
                if (err_cnt <= MAX_REPORTS)
                begin
                    $display("unexpected aabb transaction %h", aabb_if.payload);
                end
            end
            else
            begin
                want_box  = aabb_q.pop_front();
                got_flat  = aabb_if.payload;
                want_flat = want_box;
                for (int k = 0; k < 6; k++)
                begin
                    if (got_flat[(5 - k)*DATA_W +: DATA_W] != want_flat[(5 - k)*DATA_W +: DATA_W])
                    begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= MAX_REPORTS)
                        begin
                            $display("mismatch %s: expected %0d, got %0d", fld_name[k],
                                     $signed(want_flat[(5 - k)*DATA_W +: DATA_W]),
                                     $signed(got_flat[(5 - k)*DATA_W +: DATA_W]));
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        box_if.valid   = 1'b0;
        box_if.payload = '0;
        mat_q[0]       = ROW_X_RST;
        mat_q[1]       = ROW_Y_RST;
        mat_q[2]       = ROW_Z_RST;
        off_q[0]       = '0;
        off_q[1]       = '0;
        off_q[2]       = '0;

        // Identity matrix and zero offset as left by reset.
        plan_box(pack_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(0, 0, 0, 0, 0, 0));
        plan_box(pack_box(256, 256, 256, 256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b1,
                 pack_aabb(0, 0, 0, 512, 512, 512));
        plan_box(pack_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX,
                          V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX), 1'b1,
                 pack_aabb(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        plan_box(pack_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN,
                          V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN), 1'b1,
                 pack_aabb(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        plan_box(pack_box(100, -200, 300, -10, -20, -30, 5, -5, 5, 0, 0, -1), 1'b0, '0);
        plan_box(pack_box(V_MAX, V_MAX, V_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
        plan_box(pack_box(V_MIN, V_MIN, V_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));

        // Extreme offsets on x and y; the bits above the offset width carry junk on y and z.
        plan_write(REG_OFF_X, row_t'(24'h7FFFFF));
        plan_write(REG_OFF_Y, {30'h2AAAAAAA, 24'h800000});
        plan_write(REG_OFF_Z, {30'h3FFFFFFF, 24'h000100});
        plan_box(pack_box(V_MAX, V_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(V_MAX, V_MIN, 256, V_MAX, V_MIN, 256));
        plan_box(pack_box(V_MAX, V_MIN, 0, V_MAX, V_MAX, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(V_MAX, V_MIN, 256, V_MAX, V_MIN, 256));

        // Half-scale diagonal: odd inputs land exactly on a rounding tie.
        plan_write(REG_OFF_X, '0);
        plan_write(REG_OFF_Y, '0);
        plan_write(REG_OFF_Z, '0);
        plan_write(REG_ROW_X, pack_row(COEF_HALF, '0, '0));
        plan_write(REG_ROW_Y, pack_row('0, COEF_HALF, '0));
        plan_write(REG_ROW_Z, pack_row('0, '0, COEF_HALF));
        plan_write(REG_NONE_LO, {ROW_W{1'b1}});
        plan_write(REG_NONE_HI, {ROW_W{1'b1}});
        plan_box(pack_box(1, -1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 pack_aabb(1, 0, 2, 1, 0, 2));
        plan_box(pack_box(-3, 5, -7, 1, -1, 3, -1, 1, -3, V_MAX, V_MIN, 1), 1'b0, '0);

        // Full-scale coefficients of both signs.
        plan_write(REG_ROW_X, pack_row(COEF_MAX, COEF_MIN, COEF_MAX));
        plan_write(REG_ROW_Y, pack_row(COEF_MIN, COEF_MAX, COEF_MIN));
        plan_write(REG_ROW_Z, pack_row(COEF_MIN, COEF_MIN, COEF_MAX));
        plan_box(pack_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX,
                          V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX), 1'b0, '0);
        plan_box(pack_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN,
                          V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN), 1'b0, '0);
        plan_box(pack_box(V_MAX, V_MIN, 0, V_MIN, V_MAX, -1, 1, -1, V_MAX, 0, V_MIN, V_MAX),
                 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == STEP_WRITE)
            begin
                drain();
                write_reg(plan_q[i].idx, plan_q[i].val);
            end
            else
            begin
                send_box(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                3: begin idle_pct = 37; stall_pct = 37; end
                default: begin idle_pct = 0; stall_pct = 20; end
            endcase
            write_reg(REG_ROW_X, (ph == 0) ? ROW_X_RST : rand_row());
            write_reg(REG_ROW_Y, (ph == 0) ? ROW_Y_RST : rand_row());
            write_reg(REG_ROW_Z, (ph == 0) ? ROW_Z_RST : rand_row());
            write_reg(REG_OFF_X, row_t'(rand_fix()));
            write_reg(REG_OFF_Y, row_t'(rand_fix()));
            write_reg(REG_OFF_Z, row_t'(rand_fix()));
            write_reg(REG_NONE_LO, row_t'({$urandom, $urandom}));
            write_reg(REG_NONE_HI, row_t'({$urandom, $urandom}));
            if (ph == PHASES - 1)
            begin
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_box(rand_box(), 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && aabb_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
